// ===== sv/lccop_pkg.sv =====
// Shared types and constants for the load cell centre of pressure block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package lccop_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_ARM_THRESHOLD   = 2'd0,
    CFG_EMPTY_THRESHOLD = 2'd1,
    CFG_RADIUS_SCALE    = 2'd2
  } cfg_reg_t;

  localparam int CFG_INDEX_BITS = 2;

  // Reset values of the configuration registers
  localparam int ARM_RESET    = 10;
  localparam int EMPTY_RESET  = 1;
  // Radius reset is 5.5: eleven halves, scaled to the fraction width
  localparam int RADIUS_HALVES = 11;

  // Top-level sequencer
  typedef enum logic [3:0] {
    S_IDLE,
    S_RAW,
    S_TARE,
    S_SUM,
    S_DIVX_GO,
    S_DIVX,
    S_DIVY_GO,
    S_DIVY,
    S_DONE
  } seq_state_t;

  // Shared multiply/divide unit
  typedef enum logic [2:0] {
    D_IDLE,
    D_MUL,
    D_INIT,
    D_ITER,
    D_DONE
  } div_state_t;

  // Step strobes from the sequencer to the tare datapath
  typedef struct packed {
    logic load;   // take the accepted sample
    logic raw;    // form the raw sum
    logic tare;   // arm/capture decision and per-channel tare
    logic sum;    // tared sum and diagonal pair sums
  } tare_ctl_t;

endpackage

`default_nettype wire

// ===== sv/lccop_in_if.sv =====
// Input channel: one sample from each of the four load cells plus restart.
// Valid/ready handshake; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

interface lccop_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] cell_one;
  logic [SAMPLE_BITS-1:0] cell_two;
  logic [SAMPLE_BITS-1:0] cell_three;
  logic [SAMPLE_BITS-1:0] cell_four;
  logic                   restart;

  modport source (
    output valid, cell_one, cell_two, cell_three, cell_four, restart,
    input  ready
  );

  modport sink (
    input  valid, cell_one, cell_two, cell_three, cell_four, restart,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/lccop_out_if.sv =====
// Result channel: position, validity flag and the four tared channels.
// Valid/ready handshake; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

interface lccop_out_if #(
  parameter int SAMPLE_BITS = 16,
  parameter int POS_BITS    = 13
);
  logic                       valid;
  logic                       ready;
  logic signed [POS_BITS-1:0] pos_x;
  logic signed [POS_BITS-1:0] pos_y;
  logic                       pos_valid;
  logic [SAMPLE_BITS-1:0]     tared_one;
  logic [SAMPLE_BITS-1:0]     tared_two;
  logic [SAMPLE_BITS-1:0]     tared_three;
  logic [SAMPLE_BITS-1:0]     tared_four;

  modport source (
    output valid, pos_x, pos_y, pos_valid,
           tared_one, tared_two, tared_three, tared_four,
    input  ready
  );

  modport sink (
    input  valid, pos_x, pos_y, pos_valid,
           tared_one, tared_two, tared_three, tared_four,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/load_cell_center_of_pressure.sv =====
// Centre of pressure from four load cells: tare logic and X/Y position.
// Steps: raw sum, tare, tared sum, then the shared multiply/divide unit run
// once per axis (X, then Y), then the result register. A new sample is taken
// only after the last result is loaded; input ready only while the sequencer idles.
// Reset (rst_n, synchronous): baselines zero, disarmed, first sample captures,
// registers back to arm 10, empty 1, radius 5.5. Uses lccop_pkg, interfaces.
`timescale 1ns / 1ps
`default_nettype none

module load_cell_center_of_pressure
  import lccop_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 8,
  localparam int SUM_BITS    = SAMPLE_BITS + 2,
  localparam int RADIUS_BITS = 4 + FRAC_BITS,
  localparam int CFG_BITS    = (SUM_BITS > RADIUS_BITS) ? SUM_BITS : RADIUS_BITS
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  lccop_in_if.sink                       in_ch,
  lccop_out_if.source                    out_ch,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0]       cfg_wdata
);

  localparam int POS_BITS = RADIUS_BITS + 1;
  localparam logic [RADIUS_BITS-1:0] RADIUS_RESET =
    RADIUS_BITS'(RADIUS_HALVES) << (FRAC_BITS - 1);

  // Configuration registers
  logic [SUM_BITS-1:0]    arm_th_r;
  logic [SUM_BITS-1:0]    empty_th_r;
  logic [RADIUS_BITS-1:0] radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arm_th_r   <= SUM_BITS'(ARM_RESET);
      empty_th_r <= SUM_BITS'(EMPTY_RESET);
      radius_r   <= RADIUS_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_ARM_THRESHOLD:   arm_th_r   <= cfg_wdata[SUM_BITS-1:0];
        CFG_EMPTY_THRESHOLD: empty_th_r <= cfg_wdata[SUM_BITS-1:0];
        CFG_RADIUS_SCALE:    radius_r   <= cfg_wdata[RADIUS_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer signals
  seq_state_t                 state_r;
  seq_state_t                 state_nxt;
  tare_ctl_t                  tare_ctl;
  logic                       in_xfer;
  logic                       div_start;
  logic                       sel_y;
  logic                       cap_x;
  logic                       load_out;
  logic                       out_free;

  // Datapath signals
  logic [3:0][SAMPLE_BITS-1:0] cells;
  logic [3:0][SAMPLE_BITS-1:0] tared;
  logic [SUM_BITS-1:0]         tsum;
  logic [SUM_BITS-1:0]         px_pos;
  logic [SUM_BITS-1:0]         px_neg;
  logic [SUM_BITS-1:0]         py_pos;
  logic [SUM_BITS-1:0]         py_neg;
  logic                        empty;
  logic                        div_done;
  logic signed [POS_BITS-1:0]  div_quo;
  logic signed [POS_BITS-1:0]  pos_x_r;
  logic                        no_pos;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_free = !out_ch.valid || out_ch.ready;
  assign cells    = {in_ch.cell_four, in_ch.cell_three, in_ch.cell_two, in_ch.cell_one};

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (in_ch.valid) state_nxt = S_RAW;
      S_RAW:     state_nxt = S_TARE;
      S_TARE:    state_nxt = S_SUM;
      S_SUM:     state_nxt = S_DIVX_GO;
      S_DIVX_GO: state_nxt = S_DIVX;
      S_DIVX:    if (div_done) state_nxt = S_DIVY_GO;
      S_DIVY_GO: state_nxt = S_DIVY;
      S_DIVY:    if (div_done) state_nxt = S_DONE;
      S_DONE:    if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer outputs
  always_comb begin
    in_ch.ready   = 1'b0;
    tare_ctl      = '0;
    div_start     = 1'b0;
    sel_y         = 1'b0;
    cap_x         = 1'b0;
    load_out      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ch.ready   = 1'b1;
        tare_ctl.load = in_xfer;
      end
      S_RAW:     tare_ctl.raw  = 1'b1;
      S_TARE:    tare_ctl.tare = 1'b1;
      S_SUM:     tare_ctl.sum  = 1'b1;
      S_DIVX_GO: div_start     = 1'b1;
      S_DIVX:    cap_x         = div_done;
      S_DIVY_GO: begin
        div_start = 1'b1;
        sel_y     = 1'b1;
      end
      S_DIVY:    sel_y    = 1'b1;
      S_DONE:    load_out = out_free;
      default: begin
      end
    endcase
  end

  lccop_tare #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_BITS    (SUM_BITS)
  ) u_tare (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (tare_ctl),
    .cell_i     (cells),
    .restart_i  (in_ch.restart),
    .arm_th_i   (arm_th_r),
    .empty_th_i (empty_th_r),
    .tared_o    (tared),
    .sum_o      (tsum),
    .px_pos_o   (px_pos),
    .px_neg_o   (px_neg),
    .py_pos_o   (py_pos),
    .py_neg_o   (py_neg),
    .empty_o    (empty)
  );

  lccop_div #(
    .SUM_BITS    (SUM_BITS),
    .RADIUS_BITS (RADIUS_BITS),
    .POS_BITS    (POS_BITS)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (div_start),
    .pos_i   (sel_y ? py_pos : px_pos),
    .neg_i   (sel_y ? py_neg : px_neg),
    .den_i   (tsum),
    .scale_i (radius_r),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Hold X while Y is worked out
  always_ff @(posedge clk) begin
    if (cap_x) begin
      pos_x_r <= div_quo;
    end
  end

  // Empty board or zero tared sum: position forced to zero
  assign no_pos = empty || (tsum == '0);

  // Result register
  logic                       out_valid_r;
  logic signed [POS_BITS-1:0] out_x_r;
  logic signed [POS_BITS-1:0] out_y_r;
  logic                       out_pv_r;
  logic [3:0][SAMPLE_BITS-1:0] out_tared_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_x_r     <= no_pos ? '0 : pos_x_r;
      out_y_r     <= no_pos ? '0 : div_quo;
      out_pv_r    <= empty || (tsum != '0);
      out_tared_r <= tared;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pos_x       = out_x_r;
  assign out_ch.pos_y       = out_y_r;
  assign out_ch.pos_valid   = out_pv_r;
  assign out_ch.tared_one   = out_tared_r[0];
  assign out_ch.tared_two   = out_tared_r[1];
  assign out_ch.tared_three = out_tared_r[2];
  assign out_ch.tared_four  = out_tared_r[3];

endmodule

`default_nettype wire

// ===== sv/lccop_tare.sv =====
// Tare datapath: raw sum, arm/empty detector, baseline capture and the
// tared channel sums. Stepped by the sequencer; uses lccop_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lccop_tare
  import lccop_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int SUM_BITS    = SAMPLE_BITS + 2
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire tare_ctl_t                      ctl,
  input  wire logic [3:0][SAMPLE_BITS-1:0]    cell_i,
  input  wire logic                           restart_i,
  input  wire logic [SUM_BITS-1:0]            arm_th_i,
  input  wire logic [SUM_BITS-1:0]            empty_th_i,
  output logic [3:0][SAMPLE_BITS-1:0]         tared_o,
  output logic [SUM_BITS-1:0]                 sum_o,
  output logic [SUM_BITS-1:0]                 px_pos_o,
  output logic [SUM_BITS-1:0]                 px_neg_o,
  output logic [SUM_BITS-1:0]                 py_pos_o,
  output logic [SUM_BITS-1:0]                 py_neg_o,
  output logic                                empty_o
);

  logic [3:0][SAMPLE_BITS-1:0] cell_r;
  logic                        restart_r;
  logic [SUM_BITS-1:0]         raw_r;
  logic [SUM_BITS-1:0]         raw_nxt;
  logic [3:0][SAMPLE_BITS-1:0] base_r;
  logic [3:0][SAMPLE_BITS-1:0] base_nxt;
  logic                        armed_r;
  logic                        armed_nxt;
  logic                        first_r;
  logic [3:0][SAMPLE_BITS-1:0] tared_r;
  logic [3:0][SAMPLE_BITS-1:0] tared_nxt;
  logic                        empty_r;
  logic [SUM_BITS-1:0]         sum_r;
  logic [SUM_BITS-1:0]         p12_r;
  logic [SUM_BITS-1:0]         p34_r;
  logic [SUM_BITS-1:0]         p13_r;
  logic [SUM_BITS-1:0]         p24_r;
  logic                        armed_now;
  logic                        capture;

  // Sample register
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cell_r    <= cell_i;
      restart_r <= restart_i;
    end
  end

  // Raw sum of the four cells
  always_comb begin
    raw_nxt = SUM_BITS'(cell_r[0]) + SUM_BITS'(cell_r[1])
            + SUM_BITS'(cell_r[2]) + SUM_BITS'(cell_r[3]);
  end

  always_ff @(posedge clk) begin
    if (ctl.raw) begin
      raw_r <= raw_nxt;
    end
  end

  // Detector arms first; the capture test sees the updated armed state
  always_comb begin
    armed_now = armed_r | (raw_r > arm_th_i);
    capture   = first_r | restart_r | (armed_now & (raw_r < empty_th_i));
    armed_nxt = armed_now & ~capture;
    base_nxt  = capture ? cell_r : base_r;
    for (int i = 0; i < 4; i++) begin
      tared_nxt[i] = (cell_r[i] > base_nxt[i]) ? (cell_r[i] - base_nxt[i]) : '0;
    end
  end

  // Detector and baseline state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
      first_r <= 1'b1;
      base_r  <= '0;
    end else if (ctl.tare) begin
      armed_r <= armed_nxt;
      first_r <= 1'b0;
      base_r  <= base_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.tare) begin
      tared_r <= tared_nxt;
      empty_r <= raw_r < empty_th_i;
    end
  end

  // Tared sum and the diagonal pair sums
  always_ff @(posedge clk) begin
    if (ctl.sum) begin
      sum_r <= SUM_BITS'(tared_r[0]) + SUM_BITS'(tared_r[1])
             + SUM_BITS'(tared_r[2]) + SUM_BITS'(tared_r[3]);
      p12_r <= SUM_BITS'(tared_r[0]) + SUM_BITS'(tared_r[1]);
      p34_r <= SUM_BITS'(tared_r[2]) + SUM_BITS'(tared_r[3]);
      p13_r <= SUM_BITS'(tared_r[0]) + SUM_BITS'(tared_r[2]);
      p24_r <= SUM_BITS'(tared_r[1]) + SUM_BITS'(tared_r[3]);
    end
  end

  assign tared_o  = tared_r;
  assign sum_o    = sum_r;
  assign px_pos_o = p12_r;
  assign px_neg_o = p34_r;
  assign py_pos_o = p13_r;
  assign py_neg_o = p24_r;
  assign empty_o  = empty_r;

endmodule

`default_nettype wire

// ===== sv/lccop_div.sv =====
// Shared scaled-difference unit: trunc(scale * (pos - neg) / den) as a signed
// result. One multiply, then one restoring quotient bit per cycle. Uses lccop_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lccop_div
  import lccop_pkg::*;
#(
  parameter int SUM_BITS    = 18,
  parameter int RADIUS_BITS = 12,
  parameter int POS_BITS    = RADIUS_BITS + 1
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start_i,
  input  wire logic [SUM_BITS-1:0]        pos_i,
  input  wire logic [SUM_BITS-1:0]        neg_i,
  input  wire logic [SUM_BITS-1:0]        den_i,
  input  wire logic [RADIUS_BITS-1:0]     scale_i,
  output logic                            done_o,
  output logic signed [POS_BITS-1:0]      quo_o
);

  localparam int PROD_BITS = SUM_BITS + RADIUS_BITS;
  localparam int CNT_BITS  = $clog2(RADIUS_BITS);
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(RADIUS_BITS - 1);

  div_state_t              state_r;
  div_state_t              state_nxt;
  logic                    sign_r;
  logic [SUM_BITS-1:0]     mag_r;
  logic [SUM_BITS-1:0]     den_r;
  logic [PROD_BITS-1:0]    prod_r;
  logic [SUM_BITS-1:0]     rem_r;
  logic [RADIUS_BITS-1:0]  shq_r;
  logic [CNT_BITS-1:0]     cnt_r;
  logic [SUM_BITS:0]       trial;
  logic                    qbit;
  logic [POS_BITS-1:0]     q_ext;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      D_IDLE:  if (start_i) state_nxt = D_MUL;
      D_MUL:   state_nxt = D_INIT;
      D_INIT:  state_nxt = D_ITER;
      D_ITER:  if (cnt_r == CNT_LAST) state_nxt = D_DONE;
      D_DONE:  state_nxt = D_IDLE;
      default: state_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_r, shq_r[RADIUS_BITS-1]};
    qbit  = trial >= {1'b0, den_r};
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state_r)
      D_IDLE: begin
        if (start_i) begin
          sign_r <= pos_i < neg_i;
          mag_r  <= (pos_i >= neg_i) ? (pos_i - neg_i) : (neg_i - pos_i);
          den_r  <= den_i;
        end
      end
      D_MUL: begin
        prod_r <= PROD_BITS'(scale_i) * PROD_BITS'(mag_r);
      end
      D_INIT: begin
        // quotient fits RADIUS_BITS, so the upper part stays below den
        rem_r <= prod_r[PROD_BITS-1:RADIUS_BITS];
        shq_r <= prod_r[RADIUS_BITS-1:0];
        cnt_r <= '0;
      end
      D_ITER: begin
        rem_r <= qbit ? SUM_BITS'(trial - {1'b0, den_r}) : SUM_BITS'(trial);
        shq_r <= {shq_r[RADIUS_BITS-2:0], qbit};
        cnt_r <= cnt_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Result once all quotient bits are in
  always_comb begin
    q_ext  = {{(POS_BITS-RADIUS_BITS){1'b0}}, shq_r};
    quo_o  = sign_r ? -q_ext : q_ext;
    done_o = state_r == D_DONE;
  end

endmodule

`default_nettype wire
